// ----- sv/rfla_pkg.sv -----
// ----------------------------------------------------------------------------
// rfla_pkg: shared types and constants of the receive FIFO line assembler
// Request opcodes, queue entry types, back-end states and character codes.
// ----------------------------------------------------------------------------
package rfla_pkg;

  localparam int FIFO_DEPTH_DEF = 64;
  localparam int LINE_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int LEN_W          = 5;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // raw command codes on the input port
  localparam logic [1:0] CMD_RX      = 2'd0;
  localparam logic [1:0] CMD_RD_BYTE = 2'd1;
  localparam logic [1:0] CMD_RD_LINE = 2'd2;

  typedef enum logic [1:0] {
    OP_RX,
    OP_RD_BYTE,
    OP_RD_LINE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
  } entry_t;

  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [7:0] rx_byte;
  } head_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE_WAIT,
    S_LINE_POP,
    S_LINE_CHK,
    S_EMIT
  } state_t;

endpackage

// ----- sv/rfla_ram.sv -----
// ----------------------------------------------------------------------------
// rfla_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- sv/rfla_front.sv -----
// ----------------------------------------------------------------------------
// rfla_front: request intake
// Decodes each accepted command into an opcode and queues it for the back end.
// ----------------------------------------------------------------------------
module rfla_front import rfla_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_command,
  input  logic [7:0] in_rx_byte,
  input  logic       pop,
  output logic       busy,
  output head_t      head
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  entry_t         q_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  logic           do_pop;
  op_t            op_dec;

  always_comb begin
    case (in_command)
      CMD_RX:      op_dec = OP_RX;
      CMD_RD_BYTE: op_dec = OP_RD_BYTE;
      CMD_RD_LINE: op_dec = OP_RD_LINE;
      default:     op_dec = OP_NOP;
    endcase
  end

  assign busy   = (cnt_r == QCW'(QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= '{op: op_dec, rx_byte: in_rx_byte};
    end
  end

  assign head = '{valid: (cnt_r != '0), op: q_r[rd_r].op, rx_byte: q_r[rd_r].rx_byte};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QUEUE_DEPTH))
    else $error("request queue count out of range");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("request queue push lost");

endmodule

// ----- sv/rfla_back.sv -----
// ----------------------------------------------------------------------------
// rfla_back: request execution
// Runs queued requests against the ring FIFO and line store, emits results.
// ----------------------------------------------------------------------------
module rfla_back import rfla_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  head_t            head,
  output logic             pop,
  output logic             out_strobe,
  output logic [7:0]       out_data_out,
  output logic             out_data_valid,
  output logic             out_fifo_nonempty,
  output logic             out_byte_dropped,
  output logic             out_line_done,
  output logic [LEN_W-1:0] out_line_length,
  output logic             out_last
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int LW = $clog2(LINE_DEPTH);

  state_t        state_r, state_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] idx_r, idx_nxt;

  logic             strobe_r, strobe_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             valid_r, valid_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic             dropped_r, dropped_nxt;
  logic             done_r, done_nxt;
  logic [LEN_W-1:0] length_r, length_nxt;
  logic             last_r, last_nxt;

  logic          fifo_we;
  logic [7:0]    fifo_rdata;
  logic          line_we;
  logic [LW-1:0] line_raddr;
  logic [7:0]    line_rdata;

  logic [PW-1:0] wr_inc;
  logic [PW-1:0] rd_inc;
  logic          fifo_empty;
  logic          is_term;
  logic          emit_last;

  assign wr_inc     = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc     = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign fifo_empty = (wr_ptr_r == rd_ptr_r);
  assign is_term    = fifo_rdata inside {CHAR_LF, CHAR_CR};
  assign emit_last  = (idx_r + 1'b1 == len_r);

  rfla_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (wr_ptr_r),
    .wdata (head.rx_byte),
    .raddr (rd_ptr_r),
    .rdata (fifo_rdata)
  );

  rfla_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (fill_r),
    .wdata (fifo_rdata),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          case (head.op)
            OP_RD_BYTE: state_nxt = fifo_empty ? S_IDLE : S_BYTE_WAIT;
            OP_RD_LINE: state_nxt = S_LINE_POP;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_BYTE_WAIT: state_nxt = S_IDLE;
      S_LINE_POP:  state_nxt = fifo_empty ? S_IDLE : S_LINE_CHK;
      S_LINE_CHK: begin
        if (is_term) begin
          state_nxt = (fill_r == '0) ? S_IDLE : S_EMIT;
        end else begin
          state_nxt = S_LINE_POP;
        end
      end
      S_EMIT:  state_nxt = emit_last ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    pop        = 1'b0;
    fifo_we    = 1'b0;
    line_we    = 1'b0;
    line_raddr = (state_r == S_LINE_CHK) ? '0 : idx_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    data_nxt   = '0;
    valid_nxt  = 1'b0;
    dropped_nxt = 1'b0;
    done_nxt   = 1'b0;
    length_nxt = '0;
    last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.op)
            OP_RX: begin
              strobe_nxt = 1'b1;
              if (wr_inc != rd_ptr_r) begin
                fifo_we    = 1'b1;
                wr_ptr_nxt = wr_inc;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            OP_RD_BYTE: begin
              if (fifo_empty) begin
                strobe_nxt = 1'b1;
              end else begin
                rd_ptr_nxt = rd_inc;
              end
            end
            OP_RD_LINE: ;
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      S_BYTE_WAIT: begin
        strobe_nxt = 1'b1;
        data_nxt   = fifo_rdata;
        valid_nxt  = 1'b1;
      end
      S_LINE_POP: begin
        if (fifo_empty) begin
          strobe_nxt = 1'b1;
        end else begin
          rd_ptr_nxt = rd_inc;
        end
      end
      S_LINE_CHK: begin
        if (is_term) begin
          fill_nxt = '0;
          len_nxt  = fill_r;
          idx_nxt  = '0;
          if (fill_r == '0) begin
            strobe_nxt = 1'b1;
            done_nxt   = 1'b1;
          end
        end else if (fill_r != LW'(LINE_DEPTH - 1)) begin
          line_we  = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      S_EMIT: begin
        strobe_nxt = 1'b1;
        data_nxt   = line_rdata;
        valid_nxt  = 1'b1;
        done_nxt   = 1'b1;
        length_nxt = LEN_W'(len_r);
        last_nxt   = emit_last;
        idx_nxt    = idx_r + 1'b1;
      end
      default: ;
    endcase
    nonempty_nxt = (wr_ptr_nxt != rd_ptr_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    data_r     <= data_nxt;
    valid_r    <= valid_nxt;
    nonempty_r <= nonempty_nxt;
    dropped_r  <= dropped_nxt;
    done_r     <= done_nxt;
    length_r   <= length_nxt;
    last_r     <= last_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_data_out      = data_r;
  assign out_data_valid    = valid_r;
  assign out_fifo_nonempty = nonempty_r;
  assign out_byte_dropped  = dropped_r;
  assign out_line_done     = done_r;
  assign out_line_length   = length_r;
  assign out_last          = last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(LINE_DEPTH - 1))
    else $error("line fill beyond line capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && dropped_r) |-> (out_fifo_nonempty && !valid_r && !done_r))
    else $error("dropped byte reported with FIFO not full");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == S_IDLE && head.valid))
    else $error("request popped outside idle");

  a_emit_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !emit_last) |=> (state_r == S_EMIT && strobe_r && !last_r))
    else $error("line run broken");

endmodule

// ----- sv/receive_fifo_line_assembler.sv -----
// ----------------------------------------------------------------------------
// receive_fifo_line_assembler: receive ring FIFO with line assembly
// Received byte and read-byte give one result each; read-line drains the FIFO
// byte by byte (S_LINE_POP, S_LINE_CHK) through the registered-read FIFO RAM port,
// then emits one result per character of the completed line (S_EMIT).
// A two-entry request queue takes a new request per cycle until full (busy).
// Synchronous reset empties the FIFO, line fill and queue; RAM contents stay.
// ----------------------------------------------------------------------------
module receive_fifo_line_assembler import rfla_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_command,
  input  logic [7:0]       in_rx_byte,
  output logic             out_strobe,
  output logic [7:0]       out_data_out,
  output logic             out_data_valid,
  output logic             out_fifo_nonempty,
  output logic             out_byte_dropped,
  output logic             out_line_done,
  output logic [LEN_W-1:0] out_line_length,
  output logic             out_last
);

  head_t head;
  logic  pop;

  rfla_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .in_rx_byte (in_rx_byte),
    .pop        (pop),
    .busy       (busy),
    .head       (head)
  );

  rfla_back #(.FIFO_DEPTH(FIFO_DEPTH), .LINE_DEPTH(LINE_DEPTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_strobe        (out_strobe),
    .out_data_out      (out_data_out),
    .out_data_valid    (out_data_valid),
    .out_fifo_nonempty (out_fifo_nonempty),
    .out_byte_dropped  (out_byte_dropped),
    .out_line_done     (out_line_done),
    .out_line_length   (out_line_length),
    .out_last          (out_last)
  );

endmodule
